### src/nidlex_pkg.sv
// ----------------------------------------------------------------------------
// nidlex_pkg
// Shared types, codes and character classes for the number and identifier
// lexer.
// ----------------------------------------------------------------------------
package nidlex_pkg;

  localparam int MaxColumnDefault = 255;
  localparam int QueueDepth       = 8;
  localparam int MaxRecs          = 4;

  // lexer modes
  localparam logic [3:0] MODE_IDLE    = 4'd0;
  localparam logic [3:0] MODE_INT     = 4'd1;
  localparam logic [3:0] MODE_FRACT   = 4'd2;
  localparam logic [3:0] MODE_EXPS    = 4'd3;
  localparam logic [3:0] MODE_EXPSIGN = 4'd4;
  localparam logic [3:0] MODE_EXPD    = 4'd5;
  localparam logic [3:0] MODE_IDENT   = 4'd6;
  localparam logic [3:0] MODE_SLASH   = 4'd7;
  localparam logic [3:0] MODE_LCOMM   = 4'd8;
  localparam logic [3:0] MODE_BCOMM   = 4'd9;

  // record events
  localparam logic [1:0] EV_BYTE = 2'd0;
  localparam logic [1:0] EV_END  = 2'd1;
  localparam logic [1:0] EV_ERR  = 2'd2;
  localparam logic [1:0] EV_EOI  = 2'd3;

  // token kinds
  localparam logic [2:0] KIND_INT   = 3'd0;
  localparam logic [2:0] KIND_REAL  = 3'd1;
  localparam logic [2:0] KIND_IDENT = 3'd2;
  localparam logic [2:0] KIND_OP    = 3'd3;
  localparam logic [2:0] KIND_END   = 3'd4;

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_UPPER_E = 8'h45;
  localparam logic [7:0] CH_LOWER_E = 8'h65;
  localparam logic [7:0] CH_SLASH   = 8'h2f;
  localparam logic [7:0] CH_STAR    = 8'h2a;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_POINT   = 8'h2e;

  typedef struct packed {
    logic [3:0]  mode;
    logic [15:0] line;
    logic [7:0]  col;
    logic [15:0] tok_line;
    logic [7:0]  tok_col;
    logic        star;
  } lex_state_t;

  typedef struct packed {
    logic [1:0]  ev;
    logic [2:0]  kind;
    logic [7:0]  data;
    logic        first;
    logic [15:0] line;
    logic [7:0]  col;
    logic        last;
  } rec_t;

  typedef struct packed {
    rec_t [MaxRecs-1:0] recs;
    logic [2:0]         num;
  } step_out_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'd48) && (c <= 8'd57);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'd65) && (c <= 8'd90)) || ((c >= 8'd97) && (c <= 8'd122));
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic rec_t mk_rec(logic [1:0] ev, logic [2:0] kind, logic [7:0] data,
                                  logic first, logic [15:0] line, logic [7:0] col);
    rec_t r;
    r.ev    = ev;
    r.kind  = kind;
    r.data  = data;
    r.first = first;
    r.line  = line;
    r.col   = col;
    r.last  = 1'b0;
    return r;
  endfunction

endpackage

### src/nidlex_step.sv
// ----------------------------------------------------------------------------
// nidlex_step
// Single-pass lexer step: from the current state and one input word, works
// out the next state and up to four result records.
// ----------------------------------------------------------------------------
module nidlex_step #(
  parameter int MaxColumn = nidlex_pkg::MaxColumnDefault
) (
  input  nidlex_pkg::lex_state_t cur_i,
  input  logic [7:0]             char_i,
  input  logic                   eoi_i,
  output nidlex_pkg::lex_state_t nxt_o,
  output nidlex_pkg::step_out_t  res_o
);

  localparam logic [7:0] ColLimit = 8'((MaxColumn < 255) ? MaxColumn : 255);

  nidlex_pkg::lex_state_t s;
  nidlex_pkg::rec_t [nidlex_pkg::MaxRecs-1:0] r;
  logic [2:0] n;
  logic       do_idle;
  logic       is_e;
  logic       dig;

  always_comb begin
    s       = cur_i;
    r       = '0;
    n       = 3'd0;
    do_idle = 1'b0;
    dig     = nidlex_pkg::is_digit(char_i);
    is_e    = (char_i == nidlex_pkg::CH_UPPER_E) || (char_i == nidlex_pkg::CH_LOWER_E);

    if (eoi_i) begin
      // finish a pending token, then the end-of-input word
      unique case (cur_i.mode)
        nidlex_pkg::MODE_INT: begin
          r[n[1:0]] = nidlex_pkg::mk_rec(nidlex_pkg::EV_END, nidlex_pkg::KIND_INT, 8'd0,
                                         1'b0, s.tok_line, s.tok_col);
          n = n + 3'd1;
        end
        nidlex_pkg::MODE_FRACT, nidlex_pkg::MODE_EXPD: begin
          r[n[1:0]] = nidlex_pkg::mk_rec(nidlex_pkg::EV_END, nidlex_pkg::KIND_REAL, 8'd0,
                                         1'b0, s.tok_line, s.tok_col);
          n = n + 3'd1;
        end
        nidlex_pkg::MODE_EXPS, nidlex_pkg::MODE_EXPSIGN: begin
          r[n[1:0]] = nidlex_pkg::mk_rec(nidlex_pkg::EV_ERR, nidlex_pkg::KIND_INT, 8'd0,
                                         1'b0, s.tok_line, s.tok_col);
          n = n + 3'd1;
        end
        nidlex_pkg::MODE_IDENT: begin
          r[n[1:0]] = nidlex_pkg::mk_rec(nidlex_pkg::EV_END, nidlex_pkg::KIND_IDENT, 8'd0,
                                         1'b0, s.tok_line, s.tok_col);
          n = n + 3'd1;
        end
        nidlex_pkg::MODE_SLASH: begin
          r[n[1:0]] = nidlex_pkg::mk_rec(nidlex_pkg::EV_BYTE, nidlex_pkg::KIND_INT,
                                         nidlex_pkg::CH_SLASH, 1'b1, s.tok_line, s.tok_col);
          n = n + 3'd1;
          r[n[1:0]] = nidlex_pkg::mk_rec(nidlex_pkg::EV_END, nidlex_pkg::KIND_OP, 8'd0,
                                         1'b0, s.tok_line, s.tok_col);
          n = n + 3'd1;
        end
        default: ;
      endcase
      r[n[1:0]] = nidlex_pkg::mk_rec(nidlex_pkg::EV_EOI, nidlex_pkg::KIND_END, 8'd0, 1'b0,
                                     cur_i.line, cur_i.col);
      n = n + 3'd1;
      s          = '0;
      s.mode     = nidlex_pkg::MODE_IDLE;
      s.line     = 16'd1;
    end else begin
      unique case (cur_i.mode)
        nidlex_pkg::MODE_INT: begin
          if (dig || char_i == nidlex_pkg::CH_POINT || is_e) begin
            r[n[1:0]] = nidlex_pkg::mk_rec(nidlex_pkg::EV_BYTE, nidlex_pkg::KIND_INT, char_i,
                                           1'b0, s.tok_line, s.tok_col);
            n = n + 3'd1;
            if (char_i == nidlex_pkg::CH_POINT) s.mode = nidlex_pkg::MODE_FRACT;
            else if (is_e) s.mode = nidlex_pkg::MODE_EXPS;
          end else begin
            r[n[1:0]] = nidlex_pkg::mk_rec(nidlex_pkg::EV_END, nidlex_pkg::KIND_INT, 8'd0,
                                           1'b0, s.tok_line, s.tok_col);
            n = n + 3'd1;
            do_idle = 1'b1;
          end
        end
        nidlex_pkg::MODE_FRACT: begin
          if (dig || is_e) begin
            r[n[1:0]] = nidlex_pkg::mk_rec(nidlex_pkg::EV_BYTE, nidlex_pkg::KIND_INT, char_i,
                                           1'b0, s.tok_line, s.tok_col);
            n = n + 3'd1;
            if (is_e) s.mode = nidlex_pkg::MODE_EXPS;
          end else begin
            r[n[1:0]] = nidlex_pkg::mk_rec(nidlex_pkg::EV_END, nidlex_pkg::KIND_REAL, 8'd0,
                                           1'b0, s.tok_line, s.tok_col);
            n = n + 3'd1;
            do_idle = 1'b1;
          end
        end
        nidlex_pkg::MODE_EXPS, nidlex_pkg::MODE_EXPSIGN: begin
          if (dig || (cur_i.mode == nidlex_pkg::MODE_EXPS &&
                      (char_i == nidlex_pkg::CH_PLUS || char_i == nidlex_pkg::CH_MINUS))) begin
            r[n[1:0]] = nidlex_pkg::mk_rec(nidlex_pkg::EV_BYTE, nidlex_pkg::KIND_INT, char_i,
                                           1'b0, s.tok_line, s.tok_col);
            n = n + 3'd1;
            s.mode = dig ? nidlex_pkg::MODE_EXPD : nidlex_pkg::MODE_EXPSIGN;
          end else begin
            // missing exponent digits: report and drop the byte
            r[n[1:0]] = nidlex_pkg::mk_rec(nidlex_pkg::EV_ERR, nidlex_pkg::KIND_INT, char_i,
                                           1'b0, s.tok_line, s.tok_col);
            n = n + 3'd1;
            s.mode = nidlex_pkg::MODE_IDLE;
          end
        end
        nidlex_pkg::MODE_EXPD: begin
          if (dig) begin
            r[n[1:0]] = nidlex_pkg::mk_rec(nidlex_pkg::EV_BYTE, nidlex_pkg::KIND_INT, char_i,
                                           1'b0, s.tok_line, s.tok_col);
            n = n + 3'd1;
          end else begin
            r[n[1:0]] = nidlex_pkg::mk_rec(nidlex_pkg::EV_END, nidlex_pkg::KIND_REAL, 8'd0,
                                           1'b0, s.tok_line, s.tok_col);
            n = n + 3'd1;
            do_idle = 1'b1;
          end
        end
        nidlex_pkg::MODE_IDENT: begin
          if (dig || nidlex_pkg::is_alpha(char_i)) begin
            r[n[1:0]] = nidlex_pkg::mk_rec(nidlex_pkg::EV_BYTE, nidlex_pkg::KIND_INT, char_i,
                                           1'b0, s.tok_line, s.tok_col);
            n = n + 3'd1;
          end else begin
            r[n[1:0]] = nidlex_pkg::mk_rec(nidlex_pkg::EV_END, nidlex_pkg::KIND_IDENT, 8'd0,
                                           1'b0, s.tok_line, s.tok_col);
            n = n + 3'd1;
            do_idle = 1'b1;
          end
        end
        nidlex_pkg::MODE_SLASH: begin
          if (char_i == nidlex_pkg::CH_SLASH) begin
            s.mode = nidlex_pkg::MODE_LCOMM;
          end else if (char_i == nidlex_pkg::CH_STAR) begin
            s.mode = nidlex_pkg::MODE_BCOMM;
            s.star = 1'b0;
          end else begin
            // lone slash is an operator
            r[n[1:0]] = nidlex_pkg::mk_rec(nidlex_pkg::EV_BYTE, nidlex_pkg::KIND_INT,
                                           nidlex_pkg::CH_SLASH, 1'b1, s.tok_line, s.tok_col);
            n = n + 3'd1;
            r[n[1:0]] = nidlex_pkg::mk_rec(nidlex_pkg::EV_END, nidlex_pkg::KIND_OP, 8'd0,
                                           1'b0, s.tok_line, s.tok_col);
            n = n + 3'd1;
            do_idle = 1'b1;
          end
        end
        nidlex_pkg::MODE_LCOMM: begin
          if (char_i == nidlex_pkg::CH_NEWLINE) s.mode = nidlex_pkg::MODE_IDLE;
        end
        nidlex_pkg::MODE_BCOMM: begin
          if (cur_i.star && char_i == nidlex_pkg::CH_SLASH) begin
            s.mode = nidlex_pkg::MODE_IDLE;
            s.star = 1'b0;
          end else begin
            s.star = (char_i == nidlex_pkg::CH_STAR);
          end
        end
        default: do_idle = 1'b1;
      endcase

      if (do_idle) begin
        s.mode = nidlex_pkg::MODE_IDLE;
        if (!nidlex_pkg::is_space(char_i)) begin
          s.tok_line = cur_i.line;
          s.tok_col  = cur_i.col;
          if (char_i != nidlex_pkg::CH_SLASH) begin
            r[n[1:0]] = nidlex_pkg::mk_rec(nidlex_pkg::EV_BYTE, nidlex_pkg::KIND_INT, char_i,
                                           1'b1, s.tok_line, s.tok_col);
            n = n + 3'd1;
          end
          if (dig) begin
            s.mode = nidlex_pkg::MODE_INT;
          end else if (nidlex_pkg::is_alpha(char_i)) begin
            s.mode = nidlex_pkg::MODE_IDENT;
          end else if (char_i == nidlex_pkg::CH_SLASH) begin
            s.mode = nidlex_pkg::MODE_SLASH;
          end else begin
            r[n[1:0]] = nidlex_pkg::mk_rec(nidlex_pkg::EV_END, nidlex_pkg::KIND_OP, 8'd0,
                                           1'b0, s.tok_line, s.tok_col);
            n = n + 3'd1;
          end
        end
      end

      // position of the next byte
      if (char_i == nidlex_pkg::CH_NEWLINE) begin
        s.line = cur_i.line + 16'd1;
        s.col  = 8'd0;
      end else if (cur_i.col < ColLimit) begin
        s.col = cur_i.col + 8'd1;
      end
    end

    nxt_o      = s;
    res_o.recs = r;
    res_o.num  = n;
  end

endmodule

### src/number_identifier_lexer.sv
// ----------------------------------------------------------------------------
// number_identifier_lexer
// Byte-serial lexer for integers, reals, identifiers and one-byte operators,
// with line and column tracking and comment removal.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_stall_o  | char_byte_i, end_of_input_i
//  out     | output    | out_valid_o / out_stall_i| event_res_o .. last_of_run_o
//
// one input word is taken per cycle while the input does not stall; it is registered,
// lexed in one pass and its 0 to 4 result words go into an 8-entry result queue once it has room
// results leave the queue one per cycle while out_stall_i is low, so the output port sets the rate
// for words that give more than one result
// the input stalls while a word waits and fewer than four queue slots are free
// reset clears the lexer state (line 1, column 0) and empties the queue
module number_identifier_lexer #(
  parameter int MaxColumn = nidlex_pkg::MaxColumnDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_byte_i,
  input  logic        end_of_input_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  event_res_o,
  output logic [2:0]  token_kind_o,
  output logic [7:0]  out_byte_o,
  output logic        first_of_token_o,
  output logic [15:0] start_line_o,
  output logic [7:0]  start_column_o,
  output logic        last_of_run_o
);

  localparam int PtrW = $clog2(nidlex_pkg::QueueDepth);
  localparam int CntW = PtrW + 1;
  localparam logic [CntW-1:0] RoomLimit =
    CntW'(nidlex_pkg::QueueDepth - nidlex_pkg::MaxRecs);

  logic                   in_vld_q, in_vld_d;
  logic [7:0]             in_byte_q;
  logic                   in_eoi_q;
  logic                   in_accept, fire, pop;

  nidlex_pkg::lex_state_t st_q, st_d;
  nidlex_pkg::step_out_t  step_res;

  nidlex_pkg::rec_t       queue_q [nidlex_pkg::QueueDepth];
  logic [PtrW-1:0]        wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]        cnt_q;
  nidlex_pkg::rec_t       head;

  // a waiting word moves on when the queue can hold its worst case
  assign fire       = in_vld_q && (cnt_q <= RoomLimit);
  assign in_stall_o = in_vld_q && !fire;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign pop        = out_valid_o && !out_stall_i;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_accept) in_vld_d = 1'b1;
    else if (fire) in_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= char_byte_i;
      in_eoi_q  <= end_of_input_i;
    end
  end

  nidlex_step #(
    .MaxColumn(MaxColumn)
  ) u_step (
    .cur_i  (st_q),
    .char_i (in_byte_q),
    .eoi_i  (in_eoi_q),
    .nxt_o  (st_d),
    .res_o  (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= '0;
      st_q.mode <= nidlex_pkg::MODE_IDLE;
      st_q.line <= 16'd1;
    end else if (fire) begin
      st_q <= st_d;
    end
  end

  // result queue
  always_ff @(posedge clk_i) begin
    if (fire) begin
      for (int i = 0; i < nidlex_pkg::MaxRecs; i++) begin
        if (3'(i) < step_res.num) begin
          queue_q[PtrW'(wr_ptr_q + PtrW'(i))] <= '{
            ev:    step_res.recs[i].ev,
            kind:  step_res.recs[i].kind,
            data:  step_res.recs[i].data,
            first: step_res.recs[i].first,
            line:  step_res.recs[i].line,
            col:   step_res.recs[i].col,
            last:  (3'(i) == step_res.num - 3'd1)
          };
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (fire) wr_ptr_q <= wr_ptr_q + PtrW'(step_res.num);
      if (pop)  rd_ptr_q <= rd_ptr_q + PtrW'(1);
      cnt_q <= cnt_q + (fire ? CntW'(step_res.num) : CntW'(0)) - (pop ? CntW'(1) : CntW'(0));
    end
  end

  assign head             = queue_q[rd_ptr_q];
  assign out_valid_o      = (cnt_q != '0);
  assign event_res_o      = head.ev;
  assign token_kind_o     = head.kind;
  assign out_byte_o       = head.data;
  assign first_of_token_o = head.first;
  assign start_line_o     = head.line;
  assign start_column_o   = head.col;
  assign last_of_run_o    = head.last;

endmodule

### src/nidlex_checker.sv
// ----------------------------------------------------------------------------
// nidlex_checker
// Port-level checks on the lexer's result words, bound to the top level.
// ----------------------------------------------------------------------------
module nidlex_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  event_res_o,
  input logic [2:0]  token_kind_o,
  input logic [7:0]  out_byte_o,
  input logic        first_of_token_o,
  input logic [15:0] start_line_o,
  input logic [7:0]  start_column_o,
  input logic        last_of_run_o
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(event_res_o) &&
      $stable(token_kind_o) && $stable(out_byte_o) && $stable(start_line_o) &&
      $stable(start_column_o) && $stable(last_of_run_o))
    else $error("stalled result word changed");

  // end-of-input word always closes its run
  a_eoi_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o == nidlex_pkg::EV_EOI |->
      last_of_run_o && token_kind_o == nidlex_pkg::KIND_END)
    else $error("end-of-input word malformed");

  // only byte words can open a token
  a_first_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && first_of_token_o |-> event_res_o == nidlex_pkg::EV_BYTE)
    else $error("first flag on a non-byte word");

  // token end carries no byte
  a_end_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o == nidlex_pkg::EV_END |->
      out_byte_o == 8'd0 && token_kind_o != nidlex_pkg::KIND_END)
    else $error("token end word malformed");

  // after a word closing a run is taken, the next word starts a new run,
  // so an end-of-input word can never be followed by a token end
  a_eoi_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && event_res_o == nidlex_pkg::EV_EOI ##1
      out_valid_o |-> event_res_o != nidlex_pkg::EV_END)
    else $error("token end after end of input");

endmodule

bind number_identifier_lexer nidlex_checker u_nidlex_checker (.*);

### verif/number_identifier_lexer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// number_identifier_lexer_tb
// Drives byte words into the lexer and checks each result word against a
// token predictor. Directed extremes and comment cases run first, then a
// saturating long line and random token streams with idling on both
// channels.
// ----------------------------------------------------------------------------
module number_identifier_lexer_tb;

  localparam int StallLimit = 2000;
  localparam int TotalItems = 500;
  localparam logic [7:0] ColCap = 8'((nidlex_pkg::MaxColumnDefault < 255) ?
                                     nidlex_pkg::MaxColumnDefault : 255);

  class lexer_scoreboard;
    nidlex_pkg::rec_t token_recs_q[$];
    nidlex_pkg::rec_t word_recs[$];
    int          errors;
    int          item_count;
    logic [3:0]  mode;
    logic [15:0] line_no;
    logic [7:0]  col_no;
    logic [15:0] tok_line;
    logic [7:0]  tok_col;
    logic        star;

    function new();
      errors = 0;
      item_count = 0;
      clear_state();
    endfunction

    static function bit digit_ch(logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    static function bit alpha_ch(logic [7:0] c);
      return ((c >= 8'h41) && (c <= 8'h5a)) || ((c >= 8'h61) && (c <= 8'h7a));
    endfunction

    static function bit space_ch(logic [7:0] c);
      return (c == 8'h20) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    static function bit exp_ch(logic [7:0] c);
      return (c == nidlex_pkg::CH_UPPER_E) || (c == nidlex_pkg::CH_LOWER_E);
    endfunction

    function void clear_state();
      mode     = nidlex_pkg::MODE_IDLE;
      line_no  = 16'd1;
      col_no   = 8'd0;
      tok_line = 16'd0;
      tok_col  = 8'd0;
      star     = 1'b0;
    endfunction

    function int pending();
      return token_recs_q.size();
    endfunction

    function void push_rec(logic [1:0] ev, logic [2:0] kind, logic [7:0] data, logic first,
                           logic [15:0] ln, logic [7:0] cl);
      nidlex_pkg::rec_t r;
      if (word_recs.size() >= nidlex_pkg::MaxRecs) return;
      r.ev    = ev;
      r.kind  = kind;
      r.data  = data;
      r.first = first;
      r.line  = ln;
      r.col   = cl;
      r.last  = 1'b0;
      word_recs.push_back(r);
    endfunction

    // kind reads zero on everything but token ends and end of input
    function void byte_rec(logic [7:0] c, logic first);
      push_rec(nidlex_pkg::EV_BYTE, nidlex_pkg::KIND_INT, c, first, tok_line, tok_col);
    endfunction

    function void end_rec(logic [2:0] kind);
      push_rec(nidlex_pkg::EV_END, kind, 8'd0, 1'b0, tok_line, tok_col);
    endfunction

    function void err_rec(logic [7:0] c);
      push_rec(nidlex_pkg::EV_ERR, nidlex_pkg::KIND_INT, c, 1'b0, tok_line, tok_col);
    endfunction

    function void from_idle(logic [7:0] c);
      mode = nidlex_pkg::MODE_IDLE;
      if (space_ch(c)) return;
      tok_line = line_no;
      tok_col  = col_no;
      if (digit_ch(c)) begin
        byte_rec(c, 1'b1);
        mode = nidlex_pkg::MODE_INT;
      end else if (alpha_ch(c)) begin
        byte_rec(c, 1'b1);
        mode = nidlex_pkg::MODE_IDENT;
      end else if (c == nidlex_pkg::CH_SLASH) begin
        mode = nidlex_pkg::MODE_SLASH;
      end else begin
        byte_rec(c, 1'b1);
        end_rec(nidlex_pkg::KIND_OP);
      end
    endfunction

    function void lex_byte(logic [7:0] c);
      case (mode)
        nidlex_pkg::MODE_INT: begin
          if (digit_ch(c)) byte_rec(c, 1'b0);
          else if (c == nidlex_pkg::CH_POINT) begin
            byte_rec(c, 1'b0);
            mode = nidlex_pkg::MODE_FRACT;
          end else if (exp_ch(c)) begin
            byte_rec(c, 1'b0);
            mode = nidlex_pkg::MODE_EXPS;
          end else begin
            end_rec(nidlex_pkg::KIND_INT);
            from_idle(c);
          end
        end
        nidlex_pkg::MODE_FRACT: begin
          if (digit_ch(c)) byte_rec(c, 1'b0);
          else if (exp_ch(c)) begin
            byte_rec(c, 1'b0);
            mode = nidlex_pkg::MODE_EXPS;
          end else begin
            end_rec(nidlex_pkg::KIND_REAL);
            from_idle(c);
          end
        end
        nidlex_pkg::MODE_EXPS: begin
          if ((c == nidlex_pkg::CH_PLUS) || (c == nidlex_pkg::CH_MINUS)) begin
            byte_rec(c, 1'b0);
            mode = nidlex_pkg::MODE_EXPSIGN;
          end else if (digit_ch(c)) begin
            byte_rec(c, 1'b0);
            mode = nidlex_pkg::MODE_EXPD;
          end else begin
            err_rec(c);
            mode = nidlex_pkg::MODE_IDLE;
          end
        end
        nidlex_pkg::MODE_EXPSIGN: begin
          if (digit_ch(c)) begin
            byte_rec(c, 1'b0);
            mode = nidlex_pkg::MODE_EXPD;
          end else begin
            err_rec(c);
            mode = nidlex_pkg::MODE_IDLE;
          end
        end
        nidlex_pkg::MODE_EXPD: begin
          if (digit_ch(c)) byte_rec(c, 1'b0);
          else begin
            end_rec(nidlex_pkg::KIND_REAL);
            from_idle(c);
          end
        end
        nidlex_pkg::MODE_IDENT: begin
          if (digit_ch(c) || alpha_ch(c)) byte_rec(c, 1'b0);
          else begin
            end_rec(nidlex_pkg::KIND_IDENT);
            from_idle(c);
          end
        end
        nidlex_pkg::MODE_SLASH: begin
          if (c == nidlex_pkg::CH_SLASH) mode = nidlex_pkg::MODE_LCOMM;
          else if (c == nidlex_pkg::CH_STAR) begin
            mode = nidlex_pkg::MODE_BCOMM;
            star = 1'b0;
          end else begin
            byte_rec(nidlex_pkg::CH_SLASH, 1'b1);
            end_rec(nidlex_pkg::KIND_OP);
            from_idle(c);
          end
        end
        nidlex_pkg::MODE_LCOMM: begin
          if (c == nidlex_pkg::CH_NEWLINE) mode = nidlex_pkg::MODE_IDLE;
        end
        nidlex_pkg::MODE_BCOMM: begin
          if (star && (c == nidlex_pkg::CH_SLASH)) begin
            mode = nidlex_pkg::MODE_IDLE;
            star = 1'b0;
          end else begin
            star = (c == nidlex_pkg::CH_STAR);
          end
        end
        default: from_idle(c);
      endcase
    endfunction

    function void close_stream();
      case (mode)
        nidlex_pkg::MODE_INT: end_rec(nidlex_pkg::KIND_INT);
        nidlex_pkg::MODE_FRACT, nidlex_pkg::MODE_EXPD: end_rec(nidlex_pkg::KIND_REAL);
        nidlex_pkg::MODE_EXPS, nidlex_pkg::MODE_EXPSIGN: err_rec(8'd0);
        nidlex_pkg::MODE_IDENT: end_rec(nidlex_pkg::KIND_IDENT);
        nidlex_pkg::MODE_SLASH: begin
          byte_rec(nidlex_pkg::CH_SLASH, 1'b1);
          end_rec(nidlex_pkg::KIND_OP);
        end
        default: ;
      endcase
      push_rec(nidlex_pkg::EV_EOI, nidlex_pkg::KIND_END, 8'd0, 1'b0, line_no, col_no);
    endfunction

    function void note_input(logic [7:0] c, logic eoi);
      nidlex_pkg::rec_t r;
      word_recs.delete();
      item_count++;
      if (eoi) begin
        close_stream();
        clear_state();
      end else begin
        lex_byte(c);
        if (c == nidlex_pkg::CH_NEWLINE) begin
          line_no = line_no + 16'd1;
          col_no  = 8'd0;
        end else if (col_no < ColCap) begin
          col_no = col_no + 8'd1;
        end
      end
      foreach (word_recs[i]) begin
        r = word_recs[i];
        r.last = (i == word_recs.size() - 1);
        token_recs_q.push_back(r);
      end
    endfunction

    function void field_ok(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(nidlex_pkg::rec_t got);
      nidlex_pkg::rec_t want;
      if (token_recs_q.size() == 0) begin
        $display("%0t: result word with nothing expected, expected none actual %h",
                 $time, got);
        errors++;
        return;
      end
      want = token_recs_q.pop_front();
      field_ok("event_res", want.ev, got.ev);
      field_ok("token_kind", want.kind, got.kind);
      field_ok("out_byte", want.data, got.data);
      field_ok("first_of_token", want.first, got.first);
      field_ok("start_line", want.line, got.line);
      field_ok("start_column", want.col, got.col);
      field_ok("last_of_run", want.last, got.last);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  char_byte_i;
  logic        end_of_input_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  event_res_o;
  logic [2:0]  token_kind_o;
  logic [7:0]  out_byte_o;
  logic        first_of_token_o;
  logic [15:0] start_line_o;
  logic [7:0]  start_column_o;
  logic        last_of_run_o;

  lexer_scoreboard sb = new();
  bit   send_gaps_on;
  bit   recv_stall_on;
  bit   moved;
  int   quiet_cycles = 0;
  nidlex_pkg::rec_t seen_rec;

  number_identifier_lexer i_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      moved = 1'b0;
      if (in_valid_i && !in_stall_o) begin
        sb.note_input(char_byte_i, end_of_input_i);
        moved = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        seen_rec.ev    = event_res_o;
        seen_rec.kind  = token_kind_o;
        seen_rec.data  = out_byte_o;
        seen_rec.first = first_of_token_o;
        seen_rec.line  = start_line_o;
        seen_rec.col   = start_column_o;
        seen_rec.last  = last_of_run_o;
        sb.check_result(seen_rec);
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no word moved for %0d cycles", $time, StallLimit);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // result side stalls in bursts
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (recv_stall_on && ($urandom_range(0, 7) == 0)) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_word(input logic [7:0] c, input logic eoi);
    in_valid_i     <= 1'b1;
    char_byte_i    <= c;
    end_of_input_i <= eoi;
    do @(posedge clk_i); while (in_stall_o);
    if (send_gaps_on && ($urandom_range(0, 9) == 0)) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  task automatic wait_drain();
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] rand_digit();
    return 8'h30 + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_alpha();
    int idx;
    idx = $urandom_range(0, 51);
    return (idx < 26) ? 8'(8'h41 + idx) : 8'(8'h61 + idx - 26);
  endfunction

  function automatic logic [7:0] rand_alnum();
    return ($urandom_range(0, 2) == 0) ? rand_digit() : rand_alpha();
  endfunction

  function automatic logic [7:0] rand_exp();
    return $urandom_range(0, 1) ? nidlex_pkg::CH_UPPER_E : nidlex_pkg::CH_LOWER_E;
  endfunction

  function automatic logic [7:0] rand_sign();
    return $urandom_range(0, 1) ? nidlex_pkg::CH_PLUS : nidlex_pkg::CH_MINUS;
  endfunction

  // any byte that starts a one-byte operator
  function automatic logic [7:0] rand_op();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (lexer_scoreboard::digit_ch(c) || lexer_scoreboard::alpha_ch(c) ||
           lexer_scoreboard::space_ch(c) || (c == nidlex_pkg::CH_SLASH));
    return c;
  endfunction

  task automatic send_fragment();
    int         pick;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      repeat ($urandom_range(1, 4)) send_word(rand_digit(), 1'b0);
    end else if (pick < 45) begin
      repeat ($urandom_range(1, 3)) send_word(rand_digit(), 1'b0);
      if ($urandom_range(0, 3) != 0) begin
        send_word(nidlex_pkg::CH_POINT, 1'b0);
        repeat ($urandom_range(0, 3)) send_word(rand_digit(), 1'b0);
      end
      if ($urandom_range(0, 1)) begin
        send_word(rand_exp(), 1'b0);
        if ($urandom_range(0, 1)) send_word(rand_sign(), 1'b0);
        repeat ($urandom_range(1, 3)) send_word(rand_digit(), 1'b0);
      end
    end else if (pick < 50) begin
      // exponent left without digits
      send_word(rand_digit(), 1'b0);
      send_word(rand_exp(), 1'b0);
      if ($urandom_range(0, 1)) send_word(rand_sign(), 1'b0);
      if ($urandom_range(0, 4) == 0) send_word(8'($urandom_range(0, 255)), 1'b1);
      else begin
        do c = 8'($urandom_range(0, 255)); while (lexer_scoreboard::digit_ch(c));
        send_word(c, 1'b0);
      end
    end else if (pick < 70) begin
      send_word(rand_alpha(), 1'b0);
      repeat ($urandom_range(0, 5)) send_word(rand_alnum(), 1'b0);
    end else if (pick < 80) begin
      send_word(rand_op(), 1'b0);
    end else if (pick < 85) begin
      send_text("//");
      repeat ($urandom_range(0, 5)) begin
        do c = 8'($urandom_range(0, 255)); while (c == nidlex_pkg::CH_NEWLINE);
        send_word(c, 1'b0);
      end
      if ($urandom_range(0, 5) == 0) send_word(8'($urandom_range(0, 255)), 1'b1);
      else send_word(nidlex_pkg::CH_NEWLINE, 1'b0);
    end else if (pick < 90) begin
      send_text("/*");
      repeat ($urandom_range(0, 5)) begin
        case ($urandom_range(0, 2))
          0: c = nidlex_pkg::CH_STAR;
          1: c = nidlex_pkg::CH_SLASH;
          default: c = 8'($urandom_range(0, 255));
        endcase
        send_word(c, 1'b0);
      end
      send_text("*/");
    end else if (pick < 95) begin
      send_word(nidlex_pkg::CH_SLASH, 1'b0);
    end else if (pick < 98) begin
      send_word(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      send_word(8'($urandom_range(0, 255)), 1'b1);
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3: ;
      4, 5, 6: send_word(8'h20, 1'b0);
      7: send_word(nidlex_pkg::CH_NEWLINE, 1'b0);
      default: send_word(8'(8'd9 + $urandom_range(0, 4)), 1'b0);
    endcase
  endtask

  initial begin
    bit held;
    held           = 1'b0;
    send_gaps_on   = 1'b1;
    recv_stall_on  = 1'b1;
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    char_byte_i    <= 8'd0;
    end_of_input_i <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // real with every exponent part, identifier, slash then operator
    send_text("7.e+3 Zz0/+");
    send_text("1e\n");
    // the opening star does not close a block comment
    send_text("/*/*/");
    send_text("//\n");
    send_word(8'h00, 1'b0);
    send_word(8'hff, 1'b0);
    send_text("9E");
    send_word(8'hff, 1'b1);
    send_word(nidlex_pkg::CH_SLASH, 1'b0);
    send_word(8'h00, 1'b1);

    // column saturates on a long line
    repeat (90) send_text("x1 ");
    send_word(nidlex_pkg::CH_NEWLINE, 1'b0);

    while (sb.item_count < TotalItems - 1) begin
      send_fragment();
      if (!held && (sb.item_count >= TotalItems - 100)) begin
        in_valid_i <= 1'b0;
        wait_drain();
        repeat (10) @(posedge clk_i);
        held = 1'b1;
      end
      if (sb.item_count >= TotalItems - 60) begin
        send_gaps_on  = 1'b0;
        recv_stall_on = 1'b0;
      end
    end
    send_word(8'($urandom_range(0, 255)), 1'b1);
    in_valid_i <= 1'b0;

    wait_drain();
    repeat (24) @(posedge clk_i);
    if (sb.pending() != 0) $display("%0t: %0d result words never came", $time, sb.pending());
    if ((sb.errors == 0) && (sb.pending() == 0)) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

### files.f
src/nidlex_pkg.sv
src/nidlex_step.sv
src/number_identifier_lexer.sv
src/nidlex_checker.sv
verif/number_identifier_lexer_tb.sv
